/* hw/rtl/rpts_pkg.sv */
// Shared widths, register codes and fixed-point constants for the repeat-penalized top-two select.
package rpts_pkg;

    localparam int unsigned OPCODE_W          = 1;
    localparam int unsigned SCORE_W           = 32;
    localparam int unsigned CFG_W             = 17;
    localparam int unsigned INDEX_OUT_W       = 16;
    localparam int unsigned DATA_W            = 32;
    localparam int unsigned PADDR_W           = 3;
    localparam int unsigned VOCAB_MAX_DEFAULT = 65536;

    // element kinds
    localparam logic [OPCODE_W-1:0] OP_PREV = 1'b0;
    localparam logic [OPCODE_W-1:0] OP_CAND = 1'b1;

    // register index, taken from paddr[2]
    localparam logic REG_VOCAB   = 1'b0;
    localparam logic REG_PENALTY = 1'b1;

    localparam logic [CFG_W-1:0] VOCAB_RESET   = 17'd65536;
    localparam logic [CFG_W-1:0] PENALTY_RESET = 17'd0;

    // Q1.16 one and Q16.16 minus one
    localparam logic [CFG_W-1:0]          Q_ONE       = 17'd65536;
    localparam logic signed [SCORE_W-1:0] Q_MINUS_ONE = 32'shFFFF_0000;

endpackage

/* hw/rtl/repeat_penalized_top_two_select.sv */
// Top level: previous-token argmax, repeat penalty and top-two candidate select.
//
// Takes one score beat per cycle on the s_ channel while s_ready is high, with
// no bubbles between items. A previous-token vector (opcode 0) is reduced to
// its first argmax (floor -1.0). A candidate vector (opcode 1) follows, and the
// candidate at the previous index is scaled by (1 - repeat_penalty). One result
// beat leaves on the m_ channel after the last candidate. It carries the best
// index, or the second best when the best repeats the previous token and the
// second best is positive and at another index. Each beat passes an input
// register, then a register after the 32x17 penalty multiplier, then the
// best/second-best tracker that feeds the result register, which raises m_valid.
// A held result alone does not block the input. The pipe stalls, and s_ready
// drops, only while the result register is still held (m_valid high, m_ready
// low) and the tracker is finishing the next vector. After a result, all
// tracking state clears. The vector length is used clamped to 1..VOCAB_MAX and
// repeat_penalty to 0..1.0 (65536). The registers sit at byte address 0
// (vector length) and 4 (repeat_penalty). Write them only while the block
// is idle.
module repeat_penalized_top_two_select #(
    parameter int unsigned VOCAB_MAX = rpts_pkg::VOCAB_MAX_DEFAULT
) (
    input  logic                                    aclk,
    input  logic                                    aresetn,
    input  logic                                    s_valid,
    output logic                                    s_ready,
    input  logic [rpts_pkg::OPCODE_W-1:0]           s_opcode,
    input  logic signed [rpts_pkg::SCORE_W-1:0]     s_score,
    output logic                                    m_valid,
    input  logic                                    m_ready,
    output logic [rpts_pkg::INDEX_OUT_W-1:0]        m_next_index,
    output logic                                    m_repeat_avoided,
    input  logic                                    psel,
    input  logic                                    penable,
    input  logic                                    pwrite,
    input  logic [rpts_pkg::PADDR_W-1:0]            paddr,
    input  logic [rpts_pkg::DATA_W-1:0]             pwdata,
    output logic [rpts_pkg::DATA_W-1:0]             prdata,
    output logic                                    pready
);
    import rpts_pkg::*;

    localparam int unsigned CNT_W = $clog2(VOCAB_MAX + 1);
    localparam int unsigned IDX_W = $clog2(VOCAB_MAX);
    localparam int unsigned SZ_W  = (CNT_W > CFG_W) ? CNT_W : CFG_W;
    localparam int unsigned PROD_W = SCORE_W + CFG_W + 1;

    // configuration
    logic [CFG_W-1:0] vec_len_reg;
    logic [CFG_W-1:0] repeat_penalty_reg;
    logic             cfg_wr;
    logic [SZ_W-1:0]  size_ext;
    logic [SZ_W-1:0]  eff_n;

    // pipe
    logic                      en;
    logic                      res_hit;
    logic                      a_valid_reg;
    logic [OPCODE_W-1:0]       a_opcode_reg;
    logic signed [SCORE_W-1:0] a_score_reg;
    logic                      b_valid_reg;
    logic [OPCODE_W-1:0]       b_opcode_reg;
    logic signed [SCORE_W-1:0] b_score_reg;
    logic signed [SCORE_W-1:0] b_pen_reg;
    logic [CFG_W-1:0]          pen_sat;
    logic [CFG_W-1:0]          pen_factor;
    logic signed [PROD_W-1:0]  pen_prod;

    // tracking state
    logic [CNT_W-1:0]          prev_count_reg,   prev_count_next;
    logic signed [SCORE_W-1:0] prev_best_reg,    prev_best_next;
    logic [IDX_W-1:0]          prev_index_reg,   prev_index_next;
    logic                      prev_found_reg,   prev_found_next;
    logic [CNT_W-1:0]          cand_count_reg,   cand_count_next;
    logic [IDX_W-1:0]          top_index_reg,    top_index_next;
    logic signed [SCORE_W-1:0] top_score_reg,    top_score_next;
    logic [IDX_W-1:0]          runner_index_reg, runner_index_next;
    logic signed [SCORE_W-1:0] runner_score_reg, runner_score_next;

    logic [IDX_W-1:0]          cand_idx;
    logic signed [SCORE_W-1:0] seed_score;
    logic [IDX_W-1:0]          seed_index;
    logic signed [SCORE_W-1:0] cand_score;
    logic [CNT_W-1:0]          cand_inc;
    logic                      res_valid;
    logic                      res_avoid;
    logic [IDX_W-1:0]          res_pick;
    logic [IDX_W+INDEX_OUT_W-1:0] pick_ext;

    // output register
    logic                      m_valid_reg;
    logic [INDEX_OUT_W-1:0]    m_next_index_reg;
    logic                      m_repeat_avoided_reg;

    // ---------------- APB ----------------
    assign pready = 1'b1;
    assign cfg_wr = psel & penable & pwrite;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vec_len_reg        <= VOCAB_RESET;
            repeat_penalty_reg <= PENALTY_RESET;
        end else if (cfg_wr) begin
            unique case (paddr[2])
                REG_VOCAB:   vec_len_reg        <= pwdata[CFG_W-1:0];
                REG_PENALTY: repeat_penalty_reg <= pwdata[CFG_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[2])
            REG_VOCAB:   prdata = DATA_W'(vec_len_reg);
            REG_PENALTY: prdata = DATA_W'(repeat_penalty_reg);
            default:     prdata = '0;
        endcase
    end

    // effective vector length, 1..VOCAB_MAX
    assign size_ext = SZ_W'(vec_len_reg);
    always_comb begin
        if (size_ext == '0) begin
            eff_n = SZ_W'(1);
        end else if (size_ext > SZ_W'(VOCAB_MAX)) begin
            eff_n = SZ_W'(VOCAB_MAX);
        end else begin
            eff_n = size_ext;
        end
    end

    // ---------------- pipe ----------------
    // a new result may only land once the held one has left
    assign res_hit = b_valid_reg && (b_opcode_reg == OP_CAND) && (SZ_W'(cand_inc) >= eff_n);
    assign en      = !(res_hit && m_valid_reg && !m_ready);
    assign s_ready = en;

    assign pen_sat    = (repeat_penalty_reg > Q_ONE) ? Q_ONE : repeat_penalty_reg;
    assign pen_factor = Q_ONE - pen_sat;
    assign pen_prod   = a_score_reg * $signed({1'b0, pen_factor});

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
        end else if (en) begin
            a_valid_reg <= s_valid;
            b_valid_reg <= a_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            a_opcode_reg <= s_opcode;
            a_score_reg  <= s_score;
            b_opcode_reg <= a_opcode_reg;
            b_score_reg  <= a_score_reg;
            // arithmetic shift gives the floor
            b_pen_reg    <= pen_prod[SCORE_W+15:16];
        end
    end

    // ---------------- tracker ----------------
    assign cand_idx = cand_count_reg[IDX_W-1:0];
    assign cand_inc = cand_count_reg + 1'b1;

    always_comb begin
        prev_count_next   = prev_count_reg;
        prev_best_next    = prev_best_reg;
        prev_index_next   = prev_index_reg;
        prev_found_next   = prev_found_reg;
        cand_count_next   = cand_count_reg;
        top_index_next    = top_index_reg;
        top_score_next    = top_score_reg;
        runner_index_next = runner_index_reg;
        runner_score_next = runner_score_reg;
        res_valid         = 1'b0;
        res_avoid         = 1'b0;
        res_pick          = top_index_reg;
        seed_score        = top_score_reg;
        seed_index        = top_index_reg;
        cand_score        = b_score_reg;

        if (en && b_valid_reg) begin
            if (b_opcode_reg == OP_PREV) begin
                // previous vector closes once candidates start or it is full
                if (cand_count_reg == '0 && SZ_W'(prev_count_reg) < eff_n) begin
                    if (b_score_reg > prev_best_reg) begin
                        prev_best_next  = b_score_reg;
                        prev_index_next = prev_count_reg[IDX_W-1:0];
                        prev_found_next = 1'b1;
                    end
                    prev_count_next = prev_count_reg + 1'b1;
                end
            end else begin
                // first candidate seeds top with its raw score at index 0
                if (cand_count_reg == '0) begin
                    seed_score = b_score_reg;
                    seed_index = '0;
                end
                if (prev_found_reg && cand_idx == prev_index_reg) begin
                    cand_score = b_pen_reg;
                end
                top_score_next = seed_score;
                top_index_next = seed_index;
                if (cand_score > seed_score) begin
                    runner_score_next = seed_score;
                    runner_index_next = seed_index;
                    top_score_next    = cand_score;
                    top_index_next    = cand_idx;
                end else if (cand_score > runner_score_reg) begin
                    runner_score_next = cand_score;
                    runner_index_next = cand_idx;
                end
                cand_count_next = cand_inc;

                if (SZ_W'(cand_inc) >= eff_n) begin
                    res_valid = 1'b1;
                    res_avoid = prev_found_reg && top_index_next == prev_index_reg &&
                                runner_index_next != prev_index_reg &&
                                runner_score_next > 0;
                    res_pick  = res_avoid ? runner_index_next : top_index_next;
                    prev_count_next   = '0;
                    prev_best_next    = Q_MINUS_ONE;
                    prev_index_next   = '0;
                    prev_found_next   = 1'b0;
                    cand_count_next   = '0;
                    top_index_next    = '0;
                    top_score_next    = '0;
                    runner_index_next = '0;
                    runner_score_next = Q_MINUS_ONE;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prev_count_reg   <= '0;
            prev_best_reg    <= Q_MINUS_ONE;
            prev_index_reg   <= '0;
            prev_found_reg   <= 1'b0;
            cand_count_reg   <= '0;
            top_index_reg    <= '0;
            top_score_reg    <= '0;
            runner_index_reg <= '0;
            runner_score_reg <= Q_MINUS_ONE;
        end else begin
            prev_count_reg   <= prev_count_next;
            prev_best_reg    <= prev_best_next;
            prev_index_reg   <= prev_index_next;
            prev_found_reg   <= prev_found_next;
            cand_count_reg   <= cand_count_next;
            top_index_reg    <= top_index_next;
            top_score_reg    <= top_score_next;
            runner_index_reg <= runner_index_next;
            runner_score_reg <= runner_score_next;
        end
    end

    // ---------------- result register ----------------
    assign pick_ext = {{INDEX_OUT_W{1'b0}}, res_pick};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (res_valid) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (res_valid) begin
            m_next_index_reg     <= pick_ext[INDEX_OUT_W-1:0];
            m_repeat_avoided_reg <= res_avoid;
        end
    end

    assign m_valid          = m_valid_reg;
    assign m_next_index     = m_next_index_reg;
    assign m_repeat_avoided = m_repeat_avoided_reg;

endmodule

/* bench/rpts_checker.sv */
// Checker for the repeat-penalized top-two select: register tracking, pick prediction, compare.
`timescale 1ns / 100ps

module rpts_checker
    import rpts_pkg::*;
#(
    parameter int unsigned VOCAB_MAX = VOCAB_MAX_DEFAULT
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       s_valid,
    input  logic                       s_ready,
    input  logic [OPCODE_W-1:0]        s_opcode,
    input  logic signed [SCORE_W-1:0]  s_score,
    input  logic                       m_valid,
    input  logic                       m_ready,
    input  logic [INDEX_OUT_W-1:0]     m_next_index,
    input  logic                       m_repeat_avoided,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic                       pready,
    input  logic [PADDR_W-1:0]         paddr,
    input  logic [DATA_W-1:0]          pwdata,
    output int                         fail_count,
    output int                         expected_left,
    output int                         picks_seen,
    output int                         avoids_seen
);

    typedef struct packed {
        logic [INDEX_OUT_W-1:0] index;
        logic                   avoided;
    } pick_t;

    pick_t expected_picks[$];

    logic [CFG_W-1:0]          vocab_reg;
    logic [CFG_W-1:0]          penalty_reg;

    // previous-token argmax
    logic [CFG_W-1:0]          prior_cnt;
    logic signed [SCORE_W-1:0] prior_best;
    logic [INDEX_OUT_W-1:0]    prior_idx;
    logic                      prior_seen;

    // candidate top two
    logic [CFG_W-1:0]          cand_cnt;
    logic [INDEX_OUT_W-1:0]    lead_idx;
    logic signed [SCORE_W-1:0] lead_score;
    logic [INDEX_OUT_W-1:0]    second_idx;
    logic signed [SCORE_W-1:0] second_score;

    int fails;
    int picks;
    int avoids;

    function automatic logic [CFG_W-1:0] vector_len();
        if (vocab_reg == '0)
            return CFG_W'(1);
        if (vocab_reg > VOCAB_MAX)
            return CFG_W'(VOCAB_MAX);
        return vocab_reg;
    endfunction

    // floor(s * (1 - p)), p clamped to 1.0
    function automatic logic signed [SCORE_W-1:0] apply_penalty(
        input logic signed [SCORE_W-1:0] s
    );
        logic [CFG_W-1:0] p;
        logic [CFG_W-1:0] keep;
        longint           prod;
        p    = (penalty_reg > Q_ONE) ? Q_ONE : penalty_reg;
        keep = Q_ONE - p;
        prod = longint'(s) * longint'({1'b0, keep});
        return prod[47:16];
    endfunction

    task automatic clear_tracking();
        prior_cnt    = '0;
        prior_best   = Q_MINUS_ONE;
        prior_idx    = '0;
        prior_seen   = 1'b0;
        cand_cnt     = '0;
        lead_idx     = '0;
        lead_score   = '0;
        second_idx   = '0;
        second_score = Q_MINUS_ONE;
    endtask

    task automatic take_score(input logic [OPCODE_W-1:0] op,
                              input logic signed [SCORE_W-1:0] s);
        logic [CFG_W-1:0]          n;
        logic signed [SCORE_W-1:0] eff;
        pick_t                     want;
        n = vector_len();
        if (op == OP_PREV) begin
            // ignored once the vector is full or candidates have begun
            if (cand_cnt == '0 && prior_cnt < n) begin
                if (s > prior_best) begin
                    prior_best = s;
                    prior_idx  = prior_cnt[INDEX_OUT_W-1:0];
                    prior_seen = 1'b1;
                end
                prior_cnt = prior_cnt + 1'b1;
            end
        end else begin
            // first candidate seeds the lead with its raw score
            if (cand_cnt == '0) begin
                lead_score = s;
                lead_idx   = '0;
            end
            eff = (prior_seen && cand_cnt == {1'b0, prior_idx}) ? apply_penalty(s) : s;
            if (eff > lead_score) begin
                second_score = lead_score;
                second_idx   = lead_idx;
                lead_score   = eff;
                lead_idx     = cand_cnt[INDEX_OUT_W-1:0];
            end else if (eff > second_score) begin
                second_score = eff;
                second_idx   = cand_cnt[INDEX_OUT_W-1:0];
            end
            cand_cnt = cand_cnt + 1'b1;
            if (cand_cnt >= n) begin
                want.avoided = prior_seen && lead_idx == prior_idx &&
                               second_idx != prior_idx && second_score > 0;
                want.index   = want.avoided ? second_idx : lead_idx;
                expected_picks.push_back(want);
                clear_tracking();
            end
        end
    endtask

    initial begin
        fails  = 0;
        picks  = 0;
        avoids = 0;
    end

    always @(posedge aclk) begin : monitor
        pick_t got;
        pick_t want;
        if (!aresetn) begin
            vocab_reg   = VOCAB_RESET;
            penalty_reg = PENALTY_RESET;
            clear_tracking();
            expected_picks.delete();
        end else begin
            // drain first: a beat taken on this edge cannot produce this result
            if (m_valid && m_ready) begin
                got.index   = m_next_index;
                got.avoided = m_repeat_avoided;
                picks++;
                if (got.avoided)
                    avoids++;
                if (expected_picks.size() == 0) begin
                    fails++;
                    $display("%0t: result beat with nothing expected: index %0d avoided %0b",
                             $time, got.index, got.avoided);
                end else begin
                    want = expected_picks.pop_front();
                    if (got.index !== want.index) begin
                        fails++;
                        $display("%0t: next_index expected %0d got %0d",
                                 $time, want.index, got.index);
                    end
                    if (got.avoided !== want.avoided) begin
                        fails++;
                        $display("%0t: repeat_avoided expected %0b got %0b",
                                 $time, want.avoided, got.avoided);
                    end
                end
            end
            if (s_valid && s_ready)
                take_score(s_opcode, s_score);
            if (psel && penable && pwrite && pready) begin
                if (paddr[2] == REG_VOCAB)
                    vocab_reg = pwdata[CFG_W-1:0];
                else
                    penalty_reg = pwdata[CFG_W-1:0];
            end
        end
        fail_count    <= fails;
        expected_left <= expected_picks.size();
        picks_seen    <= picks;
        avoids_seen   <= avoids;
    end

endmodule

/* bench/tb_repeat_penalized_top_two_select.sv */
// Testbench top for the repeat-penalized top-two select: stimulus, handshake pacing, verdict.
`timescale 1ns / 100ps

module tb_repeat_penalized_top_two_select;
    import rpts_pkg::*;

    localparam int CYCLE_LIMIT  = 2_000_000;
    localparam int DRAIN_CYCLES = 8;
    localparam int HOLD_CYCLES  = 400;
    localparam int PHASES       = 8;

    logic                      aclk;
    logic                      aresetn;
    logic                      s_valid;
    logic                      s_ready;
    logic [OPCODE_W-1:0]       s_opcode;
    logic signed [SCORE_W-1:0] s_score;
    logic                      m_valid;
    logic                      m_ready;
    logic [INDEX_OUT_W-1:0]    m_next_index;
    logic                      m_repeat_avoided;
    logic                      psel;
    logic                      penable;
    logic                      pwrite;
    logic [PADDR_W-1:0]        paddr;
    logic [DATA_W-1:0]         pwdata;
    logic [DATA_W-1:0]         prdata;
    logic                      pready;

    int fail_count;
    int expected_left;
    int picks_seen;
    int avoids_seen;

    int cycle_count;
    int beats_sent;
    int settings_count;
    bit steady_send;
    bit long_hold;

    repeat_penalized_top_two_select u_top (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_opcode         (s_opcode),
        .s_score          (s_score),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_next_index     (m_next_index),
        .m_repeat_avoided (m_repeat_avoided),
        .psel             (psel),
        .penable          (penable),
        .pwrite           (pwrite),
        .paddr            (paddr),
        .pwdata           (pwdata),
        .prdata           (prdata),
        .pready           (pready)
    );

    rpts_checker u_checker (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_opcode         (s_opcode),
        .s_score          (s_score),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_next_index     (m_next_index),
        .m_repeat_avoided (m_repeat_avoided),
        .psel             (psel),
        .penable          (penable),
        .pwrite           (pwrite),
        .pready           (pready),
        .paddr            (paddr),
        .pwdata           (pwdata),
        .fail_count       (fail_count),
        .expected_left    (expected_left),
        .picks_seen       (picks_seen),
        .avoids_seen      (avoids_seen)
    );

    always begin
        aclk = 1'b0;
        #10;
        aclk = 1'b1;
        #10;
    end

    initial cycle_count = 0;

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d picks still expected",
                     cycle_count, expected_left);
            $display("== FAIL ==");
            $finish;
        end
    end

    // result side: mostly short ready spans and short stalls, some long stalls, some long stretches always ready
    initial begin
        int r;
        int span;
        m_ready = 1'b0;
        @(posedge aclk);
        forever begin
            if (long_hold) begin
                m_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
                long_hold = 1'b0;
            end else begin
                r = $urandom_range(0, 99);
                if (r < 55) begin
                    m_ready <= 1'b1;
                    span = $urandom_range(1, 8);
                end else if (r < 62) begin
                    m_ready <= 1'b1;
                    span = $urandom_range(50, 150);
                end else if (r < 95) begin
                    m_ready <= 1'b0;
                    span = $urandom_range(1, 3);
                end else begin
                    m_ready <= 1'b0;
                    span = $urandom_range(15, 60);
                end
                repeat (span) @(posedge aclk);
            end
        end
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (steady_send)
            return (r == 0) ? 1 : 0;
        if (r < 65)
            return 0;
        if (r < 93)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic logic signed [SCORE_W-1:0] rand_score();
        int r;
        r = $urandom_range(0, 99);
        if (r < 35)
            return $urandom;
        if (r < 75)
            return $urandom_range(0, 8 * 65536) - 4 * 65536;
        // whole values give ties and scores sitting right on the -1.0 floor
        if (r < 85)
            return (int'($urandom_range(0, 6)) - 3) * 65536;
        if (r < 92)
            return 32'sh7FFF_FFFF;
        if (r < 97)
            return 32'sh8000_0000;
        return Q_MINUS_ONE;
    endfunction

    task automatic push_beat(input logic [OPCODE_W-1:0] op,
                             input logic signed [SCORE_W-1:0] sc);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid  <= 1'b1;
        s_opcode <= op;
        s_score  <= sc;
        do @(posedge aclk); while (!s_ready);
        beats_sent++;
    endtask

    task automatic cfg_write(input logic reg_sel, input logic [CFG_W-1:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {reg_sel, 2'b00};
        pwdata  <= {15'($urandom), val};
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge aclk);
    endtask

    // stop sending and wait until every pick has come out
    task automatic settle_idle();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (expected_left != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    // previous vector (full, short, overlong or absent), then a full candidate vector
    task automatic run_sequence(input int n, input bit full_prior);
        logic signed [SCORE_W-1:0] prior_scores[];
        logic signed [SCORE_W-1:0] sc;
        int                        prior_len;
        int                        r;
        prior_scores = new[n];
        r = $urandom_range(0, 99);
        if (full_prior || r < 65)
            prior_len = n;
        else if (r < 80)
            prior_len = $urandom_range(0, n - 1);
        else if (r < 92)
            prior_len = n + $urandom_range(1, 3);
        else
            prior_len = 0;
        for (int k = 0; k < prior_len; k++) begin
            sc = rand_score();
            if (k < n)
                prior_scores[k] = sc;
            push_beat(OP_PREV, sc);
        end
        for (int k = 0; k < n; k++) begin
            // stray previous-token beats mid-candidates are dropped by the block
            if (k > 0 && $urandom_range(0, 9) == 0)
                push_beat(OP_PREV, rand_score());
            // track the previous vector so the repeat and the avoidance come up often
            if (k < prior_len && $urandom_range(0, 1) == 1)
                sc = prior_scores[k] + int'($urandom_range(0, 131072)) - 65536;
            else
                sc = rand_score();
            push_beat(OP_CAND, sc);
        end
    endtask

    task automatic run_phase(input logic [CFG_W-1:0] vocab, input logic [CFG_W-1:0] penalty,
                             input int budget, input bit full_prior, input bit hold_out,
                             input bit burst);
        int n;
        int start;
        settle_idle();
        cfg_write(REG_VOCAB, vocab);
        cfg_write(REG_PENALTY, penalty);
        settings_count++;
        n = (vocab == '0) ? 1 : (vocab > VOCAB_MAX_DEFAULT) ? VOCAB_MAX_DEFAULT : int'(vocab);
        steady_send = burst;
        if (hold_out)
            long_hold = 1'b1;
        start = beats_sent;
        do run_sequence(n, full_prior); while (beats_sent - start < budget);
        steady_send = 1'b0;
    endtask

    task automatic run_directed();
        // {opcode, score}; size 4, penalty one half
        logic [SCORE_W:0] seq[25] = '{
            // previous scores never above -1.0: no previous index
            {OP_PREV, Q_MINUS_ONE}, {OP_PREV, 32'h8000_0000},
            {OP_CAND, 32'h7FFF_FFFF}, {OP_CAND, 32'h8000_0000},
            {OP_CAND, 32'h7FFF_FFFF}, {OP_CAND, 32'h0000_0000},
            // tie in the previous vector (first wins), one extra previous beat,
            // best candidate repeats and a positive runner-up takes over
            {OP_PREV, 32'h000A_0000}, {OP_PREV, 32'h0014_0000},
            {OP_PREV, 32'h0014_0000}, {OP_PREV, 32'h0005_0000},
            {OP_PREV, 32'h7FFF_FFFF},
            {OP_CAND, 32'h0001_0000}, {OP_CAND, 32'h7FFF_FFFF},
            {OP_CAND, 32'h0002_0000}, {OP_CAND, 32'h8000_0000},
            // no previous vector; a stray previous beat after candidates began
            {OP_CAND, 32'h0000_0003}, {OP_CAND, 32'hFFFF_FFFF},
            {OP_PREV, 32'h7FFF_FFFF},
            {OP_CAND, 32'h0000_0007}, {OP_CAND, 32'h0000_0000},
            // repeat wins and the runner-up is the same index (its penalized score): nothing avoided
            {OP_PREV, 32'h0005_0000},
            {OP_CAND, 32'h0005_0000}, {OP_CAND, 32'hFFFE_0000},
            {OP_CAND, 32'hFFFD_0000}, {OP_CAND, Q_MINUS_ONE}
        };
        settle_idle();
        cfg_write(REG_VOCAB, 17'd4);
        cfg_write(REG_PENALTY, 17'h0_8000);
        settings_count++;
        foreach (seq[i])
            push_beat(seq[i][SCORE_W], seq[i][SCORE_W-1:0]);
    endtask

    initial begin
        logic [CFG_W-1:0] vocab_set[PHASES];
        logic [CFG_W-1:0] penalty_set[PHASES];
        vocab_set = '{
            17'd1, 17'd0, 17'd3, 17'd2, 17'd8, 17'd5, 17'd16, 17'd4
        };
        penalty_set = '{
            17'd65536, 17'h1_FFFF, 17'd0, 17'd40000, 17'd65537, 17'h0_FFFF, 17'd1, 17'd20000
        };
        aresetn        = 1'b0;
        s_valid        = 1'b0;
        s_opcode       = OP_PREV;
        s_score        = '0;
        psel           = 1'b0;
        penable        = 1'b0;
        pwrite         = 1'b0;
        paddr          = '0;
        pwdata         = '0;
        beats_sent     = 0;
        settings_count = 0;
        steady_send    = 1'b0;
        long_hold      = 1'b0;
        penalty_set[3] = $urandom_range(0, 65536);
        penalty_set[7] = $urandom_range(0, 65536);

        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;

        run_directed();
        // size 1 makes every candidate a result, so the long hold backs the pipe up
        for (int i = 0; i < PHASES; i++)
            run_phase(vocab_set[i], penalty_set[i], 250, 1'b0, i == 0, i == 3);

        settle_idle();
        $display("covered %0d score beats under %0d register settings; %0d picks checked, %0d %s",
                 beats_sent, settings_count, picks_seen, avoids_seen,
                 "of them replaced a repeated best index");
        if (fail_count == 0 && expected_left == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
